FILE: rtl/scij_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scij_pkg: shared types and constants
// Widths, polynomial coefficients, register indexes and the stage map of the
// inverse Jacobian solve pipeline.
// ----------------------------------------------------------------------------
package scij_pkg;

   // Stage map: one register stage per index
   localparam int STG_IN    = 0;
   localparam int STG_SC    = 1;                // sine/cosine, seven stages
   localparam int SC_STAGES = 7;
   localparam int STG_JPROD = STG_SC + SC_STAGES;
   localparam int STG_JSUM  = STG_JPROD + 1;
   localparam int STG_JDIFF = STG_JSUM + 1;
   localparam int STG_DPROD = STG_JDIFF + 1;
   localparam int STG_DET   = STG_DPROD + 1;
   localparam int STG_SEL   = STG_DET + 1;
   localparam int STG_CPROD = STG_SEL + 1;
   localparam int STG_COF   = STG_CPROD + 1;
   localparam int STG_FPROD = STG_COF + 1;
   localparam int STG_NUM   = STG_FPROD + 1;
   localparam int STG_MAG   = STG_NUM + 1;
   localparam int STG_OVF   = STG_MAG + 1;
   localparam int DIV_STEPS = 32;
   localparam int STG_DIV0  = STG_OVF + 1;
   localparam int STG_RND   = STG_DIV0 + DIV_STEPS;
   localparam int NSTG      = STG_RND + 1;

   typedef logic [NSTG-1:0]    en_type;
   typedef logic signed [15:0] force_type;
   typedef logic signed [15:0] angle_in_type;
   typedef logic signed [18:0] angle_type;
   typedef logic signed [16:0] trig_type;
   typedef logic signed [29:0] jm_type;
   typedef logic signed [30:0] cofl_type;
   typedef logic signed [60:0] cofq_type;
   typedef logic signed [63:0] det_type;
   typedef logic signed [31:0] joint_type;

   // Angle to phase scale and quarter-wave sine coefficients (Q16)
   localparam logic signed [18:0] PHASE_K = 19'sd166886;
   localparam logic [16:0] SC1     = 17'd102944;
   localparam logic [15:0] SC3     = 16'd42334;
   localparam logic [12:0] SC5     = 13'd5223;
   localparam logic [8:0]  SC7     = 9'd307;
   localparam logic [14:0] QUARTER = 15'd16384;
   localparam logic [31:0] RND16   = 32'h0000_8000;

   // Quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_LINK1  = 3'd0;
   localparam logic [2:0] CSR_LINK2  = 3'd1;
   localparam logic [2:0] CSR_LINK3  = 3'd2;
   localparam logic [2:0] CSR_THRESH = 3'd3;
   localparam logic [2:0] CSR_NUDGE  = 3'd4;

endpackage

FILE: rtl/scij_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scij_if: request and response channels
// Valid/ready channels carrying one pose and force item and one joint result.
// ----------------------------------------------------------------------------
interface scij_req_if import scij_pkg::*; ();
   logic         valid;
   logic         ready;
   force_type    force_x;
   force_type    force_y;
   force_type    moment_theta;
   angle_in_type angle_shoulder;
   angle_in_type angle_elbow;
   angle_in_type angle_wrist;

   modport source (output valid, force_x, force_y, moment_theta,
                   angle_shoulder, angle_elbow, angle_wrist, input ready);
   modport sink (input valid, force_x, force_y, moment_theta,
                 angle_shoulder, angle_elbow, angle_wrist, output ready);
endinterface

interface scij_rsp_if import scij_pkg::*; ();
   logic      valid;
   logic      ready;
   joint_type joint_out_shoulder;
   joint_type joint_out_elbow;
   joint_type joint_out_wrist;
   logic      nudged;
   logic      saturated;

   modport source (output valid, joint_out_shoulder, joint_out_elbow,
                   joint_out_wrist, nudged, saturated, input ready);
   modport sink (input valid, joint_out_shoulder, joint_out_elbow,
                 joint_out_wrist, nudged, saturated, output ready);
endinterface

FILE: rtl/scij_pipe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scij_pipe_ctrl: pipeline valid bits and stage enables
// Each stage loads when it is empty or its successor moves on, so bubbles
// close up and a stalled output holds without losing or repeating items.
// ----------------------------------------------------------------------------
module scij_pipe_ctrl import scij_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   output logic   out_valid,
   input  logic   out_ready,
   output en_type stage_en
);

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;

   // Build the enable chain from the output backward
   always_comb begin
      stage_en[NSTG-1] = !valid_ff[NSTG-1] || out_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[NSTG-1];

endmodule

FILE: rtl/scij_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scij_sincos: pipelined sine and cosine
// Angle to phase, then a degree-7 quarter-wave polynomial evaluated for the
// rising and falling halves, then quadrant sign selection. Seven stages.
// ----------------------------------------------------------------------------
module scij_sincos import scij_pkg::*; (
   input  logic      clock,
   input  en_type    stage_en,
   input  angle_type theta,
   output trig_type  sin_out,
   output trig_type  cos_out
);

   localparam int S_PH  = STG_SC;
   localparam int S_SQ  = STG_SC + 1;
   localparam int S_P5  = STG_SC + 2;
   localparam int S_P3  = STG_SC + 3;
   localparam int S_P1  = STG_SC + 4;
   localparam int S_Y   = STG_SC + 5;
   localparam int S_OUT = STG_SC + 6;

   logic signed [37:0] prod;
   logic [31:0]        ph_sum;
   logic [15:0]        ph_ff;

   logic [14:0] x_in [2];
   logic [29:0] xx [2];
   logic [23:0] t5 [2];
   logic [27:0] t3 [2];
   logic [30:0] t1 [2];
   logic [31:0] yy [2];

   logic [14:0] x_a_ff [2];
   logic [14:0] x_b_ff [2];
   logic [14:0] x_c_ff [2];
   logic [14:0] x_d_ff [2];
   logic [14:0] x2_a_ff [2];
   logic [14:0] x2_b_ff [2];
   logic [14:0] x2_c_ff [2];
   logic [12:0] p5_ff [2];
   logic [15:0] p3_ff [2];
   logic [16:0] p1_ff [2];
   logic [15:0] y_ff [2];
   logic [1:0]  q_a_ff, q_b_ff, q_c_ff, q_d_ff, q_e_ff;
   trig_type    up, dn;
   trig_type    sin_ff, cos_ff;

   // Phase in 2^-16 turn, rounded
   assign prod   = theta * PHASE_K;
   assign ph_sum = prod[31:0] + RND16;

   // Polynomial terms for the rising and falling quarter
   always_comb begin
      x_in[0] = {1'b0, ph_ff[13:0]};
      x_in[1] = QUARTER - {1'b0, ph_ff[13:0]};
      for (int i = 0; i < 2; i++) begin
         xx[i] = {15'd0, x_in[i]} * {15'd0, x_in[i]};
         t5[i] = {9'd0, x2_a_ff[i]} * {15'd0, SC7};
         t3[i] = {13'd0, x2_b_ff[i]} * {15'd0, p5_ff[i]};
         t1[i] = {16'd0, x2_c_ff[i]} * {14'd0, p3_ff[i]};
         yy[i] = ({17'd0, x_d_ff[i]} * {15'd0, p1_ff[i]}) + RND16;
      end
   end

   // Quadrant symmetry
   assign up = $signed({1'b0, y_ff[0]});
   assign dn = $signed({1'b0, y_ff[1]});

   always_ff @(posedge clock) begin
      if (stage_en[S_PH]) begin
         ph_ff <= ph_sum[31:16];
      end
      if (stage_en[S_SQ]) begin
         q_a_ff <= ph_ff[15:14];
         for (int i = 0; i < 2; i++) begin
            x_a_ff[i]  <= x_in[i];
            x2_a_ff[i] <= xx[i][28:14];
         end
      end
      if (stage_en[S_P5]) begin
         q_b_ff <= q_a_ff;
         for (int i = 0; i < 2; i++) begin
            x_b_ff[i]  <= x_a_ff[i];
            x2_b_ff[i] <= x2_a_ff[i];
            p5_ff[i]   <= SC5 - {3'd0, t5[i][23:14]};
         end
      end
      if (stage_en[S_P3]) begin
         q_c_ff <= q_b_ff;
         for (int i = 0; i < 2; i++) begin
            x_c_ff[i]  <= x_b_ff[i];
            x2_c_ff[i] <= x2_b_ff[i];
            p3_ff[i]   <= SC3 - {2'd0, t3[i][27:14]};
         end
      end
      if (stage_en[S_P1]) begin
         q_d_ff <= q_c_ff;
         for (int i = 0; i < 2; i++) begin
            x_d_ff[i] <= x_c_ff[i];
            p1_ff[i]  <= SC1 - t1[i][30:14];
         end
      end
      if (stage_en[S_Y]) begin
         q_e_ff <= q_d_ff;
         for (int i = 0; i < 2; i++) begin
            y_ff[i] <= yy[i][31:16];
         end
      end
      if (stage_en[S_OUT]) begin
         case (q_e_ff)
            QUAD_0: begin
               sin_ff <= up;
               cos_ff <= dn;
            end
            QUAD_1: begin
               sin_ff <= dn;
               cos_ff <= -up;
            end
            QUAD_2: begin
               sin_ff <= -up;
               cos_ff <= -dn;
            end
            default: begin
               sin_ff <= -dn;
               cos_ff <= up;
            end
         endcase
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

FILE: rtl/scij_jacobian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scij_jacobian: Jacobian, determinant and cofactors
// Builds the plain and the nudged Jacobian side by side, picks one by the
// determinant threshold, then forms the cofactors of the chosen matrix.
// ----------------------------------------------------------------------------
module scij_jacobian import scij_pkg::*; (
   input  logic        clock,
   input  en_type      stage_en,
   input  logic [11:0] link1_length,
   input  logic [11:0] link2_length,
   input  logic [11:0] link3_length,
   input  logic [23:0] det_threshold,
   input  trig_type    sin_in [2][3],
   input  trig_type    cos_in [2][3],
   output cofl_type    cof_lin [6],
   output cofq_type    cof_quad [3],
   output det_type     det_out,
   output logic        nudged
);

   logic signed [12:0] len [3];

   jm_type   jp_ff [2][6];
   jm_type   m_a_ff [2][6];
   jm_type   m_b_ff [2][6];
   jm_type   m_c_ff [2][6];
   jm_type   m_d_ff [2][6];
   cofl_type dd_ff [2][3];
   logic signed [60:0] dp_ff [2][3];
   det_type  det_ff [2];
   jm_type   ms_ff [6];
   det_type  det_s_ff, det_c_ff, det_q_ff;
   logic     nud_s_ff, nud_c_ff, nud_q_ff;
   logic signed [59:0] cp_ff [6];
   cofl_type cl_c_ff [6];
   cofl_type cl_q_ff [6];
   cofq_type cq_ff [3];

   det_type  thr_pos, thr_neg;
   logic     det_low;

   assign len[0] = $signed({1'b0, link1_length});
   assign len[1] = $signed({1'b0, link2_length});
   assign len[2] = $signed({1'b0, link3_length});

   // Threshold window |det| < det_threshold * 2^28
   assign thr_pos = $signed({12'd0, det_threshold, 28'd0});
   assign thr_neg = -thr_pos;
   assign det_low = (det_ff[0] < thr_pos) && (det_ff[0] > thr_neg);

   always_ff @(posedge clock) begin
      // Link products, both poses
      if (stage_en[STG_JPROD]) begin
         for (int p = 0; p < 2; p++) begin
            for (int j = 0; j < 3; j++) begin
               jp_ff[p][j]     <= len[j] * sin_in[p][j];
               jp_ff[p][3 + j] <= len[j] * cos_in[p][j];
            end
         end
      end
      // Running sums into rows 0 and 1
      if (stage_en[STG_JSUM]) begin
         for (int p = 0; p < 2; p++) begin
            m_a_ff[p][2] <= -jp_ff[p][2];
            m_a_ff[p][1] <= -jp_ff[p][2] - jp_ff[p][1];
            m_a_ff[p][0] <= -jp_ff[p][2] - jp_ff[p][1] - jp_ff[p][0];
            m_a_ff[p][5] <= jp_ff[p][5];
            m_a_ff[p][4] <= jp_ff[p][5] + jp_ff[p][4];
            m_a_ff[p][3] <= jp_ff[p][5] + jp_ff[p][4] + jp_ff[p][3];
         end
      end
      // Row 1 differences for the determinant
      if (stage_en[STG_JDIFF]) begin
         for (int p = 0; p < 2; p++) begin
            m_b_ff[p]   <= m_a_ff[p];
            dd_ff[p][0] <= 31'(m_a_ff[p][4]) - 31'(m_a_ff[p][5]);
            dd_ff[p][1] <= 31'(m_a_ff[p][3]) - 31'(m_a_ff[p][5]);
            dd_ff[p][2] <= 31'(m_a_ff[p][3]) - 31'(m_a_ff[p][4]);
         end
      end
      if (stage_en[STG_DPROD]) begin
         for (int p = 0; p < 2; p++) begin
            m_c_ff[p] <= m_b_ff[p];
            for (int j = 0; j < 3; j++) begin
               dp_ff[p][j] <= m_b_ff[p][j] * dd_ff[p][j];
            end
         end
      end
      if (stage_en[STG_DET]) begin
         for (int p = 0; p < 2; p++) begin
            m_d_ff[p]  <= m_c_ff[p];
            det_ff[p]  <= 64'(dp_ff[p][0]) - 64'(dp_ff[p][1]) + 64'(dp_ff[p][2]);
         end
      end
      // Pick the plain or nudged matrix
      if (stage_en[STG_SEL]) begin
         nud_s_ff <= det_low;
         det_s_ff <= det_low ? det_ff[1] : det_ff[0];
         if (det_low) begin
            ms_ff <= m_d_ff[1];
         end else begin
            ms_ff <= m_d_ff[0];
         end
      end
      // Cofactors: linear ones and quadratic products
      if (stage_en[STG_CPROD]) begin
         nud_c_ff   <= nud_s_ff;
         det_c_ff   <= det_s_ff;
         cp_ff[0]   <= ms_ff[1] * ms_ff[5];
         cp_ff[1]   <= ms_ff[2] * ms_ff[4];
         cp_ff[2]   <= ms_ff[2] * ms_ff[3];
         cp_ff[3]   <= ms_ff[0] * ms_ff[5];
         cp_ff[4]   <= ms_ff[0] * ms_ff[4];
         cp_ff[5]   <= ms_ff[1] * ms_ff[3];
         cl_c_ff[0] <= 31'(ms_ff[4]) - 31'(ms_ff[5]);
         cl_c_ff[1] <= 31'(ms_ff[5]) - 31'(ms_ff[3]);
         cl_c_ff[2] <= 31'(ms_ff[3]) - 31'(ms_ff[4]);
         cl_c_ff[3] <= 31'(ms_ff[2]) - 31'(ms_ff[1]);
         cl_c_ff[4] <= 31'(ms_ff[0]) - 31'(ms_ff[2]);
         cl_c_ff[5] <= 31'(ms_ff[1]) - 31'(ms_ff[0]);
      end
      if (stage_en[STG_COF]) begin
         nud_q_ff <= nud_c_ff;
         det_q_ff <= det_c_ff;
         cl_q_ff  <= cl_c_ff;
         for (int j = 0; j < 3; j++) begin
            cq_ff[j] <= 61'(cp_ff[2*j]) - 61'(cp_ff[2*j + 1]);
         end
      end
   end

   assign cof_lin  = cl_q_ff;
   assign cof_quad = cq_ff;
   assign det_out  = det_q_ff;
   assign nudged   = nud_q_ff;

endmodule

FILE: rtl/scij_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scij_div_lane: one output component
// Forms the cofactor-force numerator, scales by 2^8 and divides by the
// determinant one quotient bit per stage, then rounds and saturates.
// ----------------------------------------------------------------------------
module scij_div_lane import scij_pkg::*; (
   input  logic      clock,
   input  en_type    stage_en,
   input  cofl_type  cof_a,
   input  cofl_type  cof_b,
   input  cofq_type  cof_c,
   input  force_type force_in [3],
   input  det_type   det_in,
   output joint_type joint_out,
   output logic      sat_out
);

   logic signed [46:0] pa_ff, pb_ff;
   logic signed [47:0] plo_ff;
   logic signed [45:0] phi_ff;
   det_type            det_f_ff, det_n_ff;
   logic signed [47:0] pab;
   logic signed [77:0] num_in;
   logic signed [77:0] num_ff;

   logic [77:0] nmag_ff;
   logic [63:0] dmag_m_ff;
   logic        neg_m_ff, dz_m_ff;
   logic [85:0] nsh;

   logic [63:0] rem_ff  [DIV_STEPS+1];
   logic [31:0] low_ff  [DIV_STEPS+1];
   logic [31:0] q_ff    [DIV_STEPS+1];
   logic [63:0] dmag_ff [DIV_STEPS+1];
   logic        neg_ff  [DIV_STEPS+1];
   logic        dz_ff   [DIV_STEPS+1];
   logic        ovf_ff  [DIV_STEPS+1];

   logic [64:0] trial [DIV_STEPS];
   logic [64:0] diff  [DIV_STEPS];
   logic        ge    [DIV_STEPS];

   logic        rnd;
   logic [32:0] qr, lim, qmag;
   logic        over;
   logic [32:0] sval;
   joint_type   joint_ff;
   logic        sat_ff;

   // Numerator: (ca*fx + cb*fy) * 2^14 + cc*m
   assign pab    = 48'(pa_ff) + 48'(pb_ff);
   assign num_in = 78'($signed({pab, 14'd0})) + 78'($signed({phi_ff, 31'd0}))
                   + 78'(plo_ff);
   assign nsh    = {nmag_ff, 8'd0};

   // Restoring division trial subtract, one quotient bit per stage
   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial[k] = {rem_ff[k], low_ff[k][31]};
         diff[k]  = trial[k] - {1'b0, dmag_ff[k]};
         ge[k]    = trial[k] >= {1'b0, dmag_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_FPROD]) begin
         pa_ff    <= cof_a * force_in[0];
         pb_ff    <= cof_b * force_in[1];
         plo_ff   <= $signed({1'b0, cof_c[30:0]}) * force_in[2];
         phi_ff   <= $signed(cof_c[60:31]) * force_in[2];
         det_f_ff <= det_in;
      end
      if (stage_en[STG_NUM]) begin
         num_ff   <= num_in;
         det_n_ff <= det_f_ff;
      end
      // Sign and magnitude
      if (stage_en[STG_MAG]) begin
         neg_m_ff  <= num_ff[77] ^ det_n_ff[63];
         nmag_ff   <= num_ff[77] ? 78'(-num_ff) : 78'(num_ff);
         dmag_m_ff <= det_n_ff[63] ? 64'(-det_n_ff) : 64'(det_n_ff);
         dz_m_ff   <= (det_n_ff == '0);
      end
      // Flag a quotient beyond 32 bits for saturation and seed the remainder
      if (stage_en[STG_OVF]) begin
         ovf_ff[0]  <= {10'd0, nsh[85:32]} >= dmag_m_ff;
         rem_ff[0]  <= {10'd0, nsh[85:32]};
         low_ff[0]  <= nsh[31:0];
         q_ff[0]    <= '0;
         dmag_ff[0] <= dmag_m_ff;
         neg_ff[0]  <= neg_m_ff;
         dz_ff[0]   <= dz_m_ff;
      end
      // Advance the division stages
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (stage_en[STG_DIV0 + k]) begin
            rem_ff[k+1]  <= ge[k] ? diff[k][63:0] : trial[k][63:0];
            low_ff[k+1]  <= {low_ff[k][30:0], 1'b0};
            q_ff[k+1]    <= {q_ff[k][30:0], ge[k]};
            dmag_ff[k+1] <= dmag_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            dz_ff[k+1]   <= dz_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
         end
      end
   end

   // Round half up on the magnitude, clip to the signed 32-bit range
   always_comb begin
      rnd  = {rem_ff[DIV_STEPS], 1'b0} >= {1'b0, dmag_ff[DIV_STEPS]};
      qr   = {1'b0, q_ff[DIV_STEPS]} + {32'd0, rnd};
      lim  = neg_ff[DIV_STEPS] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      over = ovf_ff[DIV_STEPS] || (qr > lim);
      qmag = over ? lim : qr;
      sval = neg_ff[DIV_STEPS] ? -qmag : qmag;
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_RND]) begin
         joint_ff <= dz_ff[DIV_STEPS] ? '0 : $signed(sval[31:0]);
         sat_ff   <= dz_ff[DIV_STEPS] || over;
      end
   end

   assign joint_out = joint_ff;
   assign sat_out   = sat_ff;

endmodule

FILE: rtl/scara_inverse_jacobian_solve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scara_inverse_jacobian_solve: inverse Jacobian force solve, 3-link arm
// Takes joint angles and a planar force and moment on req_chan and returns
// J^-1 times the force as three Q16.16 joint values on rsp_chan.
//
// Channels are valid/ready; an item moves when both are high. Link lengths,
// determinant threshold and angle nudge are written on the csr_ port; the
// user must write them only while no item is in flight, which the block
// itself does not enforce. One item is accepted every cycle while the
// output is not stalled; items pass the sine, Jacobian and cofactor stages
// and then the 32-stage restoring divider in each output lane.
// Each stage loads when empty, so bubbles close up; when the receiver drops
// ready the items back up stage by stage and req_chan.ready falls only once
// every stage holds an item. Nothing is lost or repeated.
// Reset clears all valid bits and loads the default registers: links 100 mm,
// threshold 100, nudge 410.
// ----------------------------------------------------------------------------
module scara_inverse_jacobian_solve import scij_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   scij_req_if.sink    req_chan,
   scij_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   en_type stage_en;

   logic [11:0] link1_ff, link2_ff, link3_ff, nudge_ff;
   logic [23:0] thresh_ff;

   angle_type t1, t2, t3, n1, n2, n3;
   angle_type ang_ff [2][3];
   force_type f_ff [3];

   trig_type sin_w [2][3];
   trig_type cos_w [2][3];
   cofl_type cof_lin [6];
   cofq_type cof_quad [3];
   det_type  det_w;
   logic     nud_w;

   logic      nud_ff [STG_FPROD:STG_RND];
   joint_type joint_w [3];
   logic      sat_w [3];

   // Pipeline control
   scij_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .stage_en  (stage_en)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         link1_ff  <= 12'd100;
         link2_ff  <= 12'd100;
         link3_ff  <= 12'd100;
         thresh_ff <= 24'd100;
         nudge_ff  <= 12'd410;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINK1:  link1_ff  <= csr_wdata[11:0];
            CSR_LINK2:  link2_ff  <= csr_wdata[11:0];
            CSR_LINK3:  link3_ff  <= csr_wdata[11:0];
            CSR_THRESH: thresh_ff <= csr_wdata;
            CSR_NUDGE:  nudge_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Cumulative angles, plain and nudged
   assign t1 = 19'(req_chan.angle_shoulder);
   assign t2 = t1 + 19'(req_chan.angle_elbow);
   assign t3 = t2 + 19'(req_chan.angle_wrist);
   assign n1 = $signed({7'd0, nudge_ff});
   assign n2 = $signed({6'd0, nudge_ff, 1'b0});
   assign n3 = n1 + n2;

   always_ff @(posedge clock) begin
      if (stage_en[STG_IN]) begin
         f_ff[0]     <= req_chan.force_x;
         f_ff[1]     <= req_chan.force_y;
         f_ff[2]     <= req_chan.moment_theta;
         ang_ff[0][0] <= t1;
         ang_ff[0][1] <= t2;
         ang_ff[0][2] <= t3;
         ang_ff[1][0] <= t1 + n1;
         ang_ff[1][1] <= t2 + n2;
         ang_ff[1][2] <= t3 + n3;
      end
   end

   // Six sine/cosine units: three joints for each pose
   for (genvar p = 0; p < 2; p++) begin : g_pose
      for (genvar j = 0; j < 3; j++) begin : g_joint
         scij_sincos u_sc (
            .clock    (clock),
            .stage_en (stage_en),
            .theta    (ang_ff[p][j]),
            .sin_out  (sin_w[p][j]),
            .cos_out  (cos_w[p][j])
         );
      end
   end

   scij_jacobian u_jac (
      .clock         (clock),
      .stage_en      (stage_en),
      .link1_length  (link1_ff),
      .link2_length  (link2_ff),
      .link3_length  (link3_ff),
      .det_threshold (thresh_ff),
      .sin_in        (sin_w),
      .cos_in        (cos_w),
      .cof_lin       (cof_lin),
      .cof_quad      (cof_quad),
      .det_out       (det_w),
      .nudged        (nud_w)
   );

   // Forces in f_ff are overwritten while the item is in the sine and Jacobian
   // stages, so carry them alongside
   force_type f_dl_ff [STG_SC:STG_COF][3];

   always_ff @(posedge clock) begin
      if (stage_en[STG_SC]) begin
         f_dl_ff[STG_SC] <= f_ff;
      end
      for (int s = STG_SC + 1; s <= STG_COF; s++) begin
         if (stage_en[s]) begin
            f_dl_ff[s] <= f_dl_ff[s-1];
         end
      end
   end

   // One divider lane per output component
   for (genvar i = 0; i < 3; i++) begin : g_lane
      scij_div_lane u_lane (
         .clock     (clock),
         .stage_en  (stage_en),
         .cof_a     (cof_lin[i]),
         .cof_b     (cof_lin[3 + i]),
         .cof_c     (cof_quad[i]),
         .force_in  (f_dl_ff[STG_COF]),
         .det_in    (det_w),
         .joint_out (joint_w[i]),
         .sat_out   (sat_w[i])
      );
   end

   // Carry the nudge flag down to the output
   always_ff @(posedge clock) begin
      if (stage_en[STG_FPROD]) begin
         nud_ff[STG_FPROD] <= nud_w;
      end
      for (int s = STG_FPROD + 1; s <= STG_RND; s++) begin
         if (stage_en[s]) begin
            nud_ff[s] <= nud_ff[s-1];
         end
      end
   end

   assign rsp_chan.joint_out_shoulder = joint_w[0];
   assign rsp_chan.joint_out_elbow    = joint_w[1];
   assign rsp_chan.joint_out_wrist    = joint_w[2];
   assign rsp_chan.nudged             = nud_ff[STG_RND];
   assign rsp_chan.saturated          = sat_w[0] | sat_w[1] | sat_w[2];

endmodule
